>>> src/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants for the precursor tolerance merge block.
// ----------------------------------------------------------------------------
package ptm_pkg;

  // value and field widths
  localparam int VAL_W       = 32;
  localparam int QNUM_W      = 16;
  localparam int REQ_W       = 2;
  localparam int CFG_INDEX_W = 8;

  // default reference table depth
  localparam int DEF_TABLE_DEPTH = 256;

  // register reset values
  localparam logic [VAL_W-1:0] MZ_TOL_RESET   = 32'd655;
  localparam logic [VAL_W-1:0] TIME_TOL_RESET = 32'd655360;

  // saturation value of the query number
  localparam logic [QNUM_W-1:0] QNUM_MAX = 16'hFFFF;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MZ_TOL   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TIME_TOL = 8'd1;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // tolerance window settings
  typedef struct packed {
    logic [VAL_W-1:0] mz;
    logic [VAL_W-1:0] rt;
  } tol_t;

  // outcome of one entry comparison
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] merged;
  } match_t;

endpackage

>>> src/ptm_ram.sv
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ptm_match.sv
// ----------------------------------------------------------------------------
// ptm_match
// Tolerance window test of a query against one reference entry, with the
// mean of the two m/z values.
// ----------------------------------------------------------------------------
module ptm_match (
  input  logic [ptm_pkg::VAL_W-1:0] query_mz_i,
  input  logic [ptm_pkg::VAL_W-1:0] query_rt_i,
  input  logic [ptm_pkg::VAL_W-1:0] entry_mz_i,
  input  logic [ptm_pkg::VAL_W-1:0] entry_rt_i,
  input  ptm_pkg::tol_t             tol_i,
  output ptm_pkg::match_t           match_o
);

  logic [ptm_pkg::VAL_W-1:0] mz_diff;
  logic [ptm_pkg::VAL_W-1:0] rt_diff;
  logic [ptm_pkg::VAL_W:0]   mz_sum;

  // absolute differences
  assign mz_diff = (query_mz_i >= entry_mz_i) ? (query_mz_i - entry_mz_i)
                                              : (entry_mz_i - query_mz_i);
  assign rt_diff = (query_rt_i >= entry_rt_i) ? (query_rt_i - entry_rt_i)
                                              : (entry_rt_i - query_rt_i);

  // sum kept one bit wider so it never wraps
  assign mz_sum = {1'b0, query_mz_i} + {1'b0, entry_mz_i};

  assign match_o.hit    = (mz_diff <= tol_i.mz) && (rt_diff <= tol_i.rt);
  assign match_o.merged = mz_sum[ptm_pkg::VAL_W:1];

endmodule

>>> src/ptm_ctrl.sv
// ----------------------------------------------------------------------------
// ptm_ctrl
// Request sequencer: appends loads to the table memory, walks the table for
// each query one entry per cycle and holds the result item in an output
// register.
// ----------------------------------------------------------------------------
module ptm_ctrl #(
  parameter int TABLE_DEPTH = ptm_pkg::DEF_TABLE_DEPTH,
  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW         = $clog2(TABLE_DEPTH + 1),
  localparam int EW         = 2 * ptm_pkg::VAL_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptm_pkg::tol_t              tol_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ptm_pkg::REQ_W-1:0]  req_type_i,
  input  logic [ptm_pkg::VAL_W-1:0]  mass_to_charge_i,
  input  logic [ptm_pkg::VAL_W-1:0]  retention_time_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ptm_pkg::QNUM_W-1:0] query_number_o,
  output logic [ptm_pkg::VAL_W-1:0]  merged_mass_o,
  output logic                       matched_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [EW-1:0]              ram_wdata_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  logic [EW-1:0]              ram_rdata_i
);

  ptm_pkg::state_e state_q, state_d;
  ptm_pkg::req_e   req;
  ptm_pkg::match_t match;

  logic [CW-1:0]                 count_q, count_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [ptm_pkg::QNUM_W-1:0]    qnum_q, qnum_d;
  logic                          pend_q, pend_d;
  logic                          res_hit_q, res_hit_d;
  logic [ptm_pkg::VAL_W-1:0]     res_mass_q, res_mass_d;
  logic                          out_valid_q, out_valid_d;
  logic [ptm_pkg::QNUM_W-1:0]    out_qnum_q;
  logic [ptm_pkg::VAL_W-1:0]     out_mass_q;
  logic                          out_hit_q;
  logic [ptm_pkg::VAL_W-1:0]     q_mz_q;
  logic [ptm_pkg::VAL_W-1:0]     q_rt_q;

  logic accept;
  logic query_start;
  logic found;
  logic issue;
  logic out_free;
  logic out_load;

  assign req         = ptm_pkg::req_e'(req_type_i);
  assign accept      = in_valid_i && in_ready_o;
  assign query_start = accept && (req == ptm_pkg::REQ_QUERY);
  assign found       = pend_q && match.hit;
  assign issue       = (state_q == ptm_pkg::ST_SCAN) && (idx_q < count_q) && !found;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ptm_pkg::ST_FINISH) && out_free;

  // compare the entry read in the previous cycle
  ptm_match u_match (
    .query_mz_i (q_mz_q),
    .query_rt_i (q_rt_q),
    .entry_mz_i (ram_rdata_i[EW-1:ptm_pkg::VAL_W]),
    .entry_rt_i (ram_rdata_i[ptm_pkg::VAL_W-1:0]),
    .tol_i      (tol_i),
    .match_o    (match)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptm_pkg::ST_IDLE: begin
        if (query_start) begin
          state_d = ptm_pkg::ST_SCAN;
        end
      end
      ptm_pkg::ST_SCAN: begin
        if (found || !issue) begin
          state_d = ptm_pkg::ST_FINISH;
        end
      end
      ptm_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = ptm_pkg::ST_IDLE;
        end
      end
      default: state_d = ptm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q[AW-1:0];
    ram_wdata_o = {mass_to_charge_i, retention_time_i};
    ram_re_o    = issue;
    ram_raddr_o = idx_q[AW-1:0];
    count_d     = count_q;
    idx_d       = idx_q;
    qnum_d      = qnum_q;
    pend_d      = pend_q;
    res_hit_d   = res_hit_q;
    res_mass_d  = res_mass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ptm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (req)
            ptm_pkg::REQ_CLEAR: begin
              count_d = '0;
              qnum_d  = '0;
            end
            ptm_pkg::REQ_LOAD: begin
              // full table drops the entry
              if (count_q < CW'(TABLE_DEPTH)) begin
                ram_we_o = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            ptm_pkg::REQ_QUERY: begin
              if (qnum_q != ptm_pkg::QNUM_MAX) begin
                qnum_d = qnum_q + ptm_pkg::QNUM_W'(1);
              end
              idx_d      = '0;
              pend_d     = 1'b0;
              res_hit_d  = 1'b0;
              res_mass_d = mass_to_charge_i;
            end
            default: ;
          endcase
        end
      end
      ptm_pkg::ST_SCAN: begin
        // read ahead one entry, stop at the first hit
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (found) begin
          res_hit_d  = 1'b1;
          res_mass_d = match.merged;
        end
      end
      ptm_pkg::ST_FINISH: begin
        pend_d = 1'b0;
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptm_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      qnum_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      qnum_q      <= qnum_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_hit_q  <= res_hit_d;
    res_mass_q <= res_mass_d;
    if (query_start) begin
      q_mz_q <= mass_to_charge_i;
      q_rt_q <= retention_time_i;
    end
    if (out_load) begin
      out_qnum_q <= qnum_q;
      out_mass_q <= res_mass_q;
      out_hit_q  <= res_hit_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign query_number_o = out_qnum_q;
  assign merged_mass_o  = out_mass_q;
  assign matched_o      = out_hit_q;

endmodule

>>> src/precursor_tolerance_merge.sv
// ----------------------------------------------------------------------------
// precursor_tolerance_merge
// Matches query m/z and retention time pairs against a reference table
// within configurable tolerance windows.
// ----------------------------------------------------------------------------
// Clear and load items complete on acceptance; a load appends to a table memory
// of TABLE_DEPTH entries and is dropped once the table is full. A query walks
// the loaded entries in load order, one memory read and one window compare per
// cycle, as the table memory has a single read port, and stops at the first entry
// inside both windows. One item is worked on at a time; the result item sits in
// an output register, so a new item is taken while it waits.
// Tolerances may be written at any time the block is idle; the table needs no
// clearing pass after reset.
module precursor_tolerance_merge #(
  parameter int TABLE_DEPTH = ptm_pkg::DEF_TABLE_DEPTH,
  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int EW         = 2 * ptm_pkg::VAL_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ptm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ptm_pkg::VAL_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptm_pkg::REQ_W-1:0]       req_type_i,
  input  logic [ptm_pkg::VAL_W-1:0]       mass_to_charge_i,
  input  logic [ptm_pkg::VAL_W-1:0]       retention_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptm_pkg::QNUM_W-1:0]      query_number_o,
  output logic [ptm_pkg::VAL_W-1:0]       merged_mass_o,
  output logic                            matched_o
);

  ptm_pkg::tol_t tol_q, tol_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  // tolerance registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    tol_d = tol_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == ptm_pkg::CFG_IDX_MZ_TOL) begin
        tol_d.mz = cfg_data_i;
      end
      if (cfg_index_i == ptm_pkg::CFG_IDX_TIME_TOL) begin
        tol_d.rt = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q.mz <= ptm_pkg::MZ_TOL_RESET;
      tol_q.rt <= ptm_pkg::TIME_TOL_RESET;
    end else begin
      tol_q <= tol_d;
    end
  end

  // reference table: m/z in the upper half, time in the lower half
  ptm_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request sequencer
  ptm_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tol_i            (tol_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .mass_to_charge_i (mass_to_charge_i),
    .retention_time_i (retention_time_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .query_number_o   (query_number_o),
    .merged_mass_o    (merged_mass_o),
    .matched_o        (matched_o),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata)
  );

endmodule

>>> verif/precursor_tolerance_merge_tb.sv
// ----------------------------------------------------------------------------
// precursor_tolerance_merge_tb
// Self-checking bench for the precursor tolerance merge block. A queue of
// pending items (clears, loads, queries and tolerance writes) feeds a clocked
// driver, a scoreboard model predicts each query result on acceptance, and a
// clocked monitor compares every result item against the oldest prediction.
// ----------------------------------------------------------------------------
module precursor_tolerance_merge_tb;
  import ptm_pkg::*;

  localparam int DEPTH         = DEF_TABLE_DEPTH;
  localparam int IDLE_PCT      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = DEPTH + 8;

  // request code the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic                   is_cfg;
    logic                   calm;
    logic [CFG_INDEX_W-1:0] index;
    logic [VAL_W-1:0]       data;
    logic [REQ_W-1:0]       req;
    logic [VAL_W-1:0]       mz;
    logic [VAL_W-1:0]       rt;
  } item_t;

  typedef struct {
    logic [QNUM_W-1:0] qnum;
    logic [VAL_W-1:0]  merged;
    logic              hit;
  } merge_t;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_valid_i      = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i      = '0;
  logic [VAL_W-1:0]       cfg_data_i       = '0;
  logic                   in_valid_i       = 1'b0;
  logic                   in_ready_o;
  logic [REQ_W-1:0]       req_type_i       = '0;
  logic [VAL_W-1:0]       mass_to_charge_i = '0;
  logic [VAL_W-1:0]       retention_time_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i      = 1'b0;
  logic [QNUM_W-1:0]      query_number_o;
  logic [VAL_W-1:0]       merged_mass_o;
  logic                   matched_o;

  // pending items and predicted results
  item_t  item_queue[$];
  merge_t merge_queue[$];
  int     mismatch_count = 0;
  int     settle_count   = 0;
  bit     calm_now       = 1'b0;

  // scoreboard copy of the block state
  logic [VAL_W-1:0]  lib_mass[DEPTH];
  logic [VAL_W-1:0]  lib_time[DEPTH];
  int                lib_count = 0;
  logic [QNUM_W-1:0] query_seq = '0;
  logic [VAL_W-1:0]  win_mz    = MZ_TOL_RESET;
  logic [VAL_W-1:0]  win_rt    = TIME_TOL_RESET;

  // generator side bookkeeping
  logic [VAL_W-1:0] staged_mass[DEPTH];
  logic [VAL_W-1:0] staged_time[DEPTH];
  int               staged_count = 0;
  logic [VAL_W-1:0] gen_mz_tol   = MZ_TOL_RESET;
  logic [VAL_W-1:0] gen_rt_tol   = TIME_TOL_RESET;
  bit               gen_calm     = 1'b0;
  int               stim_total   = 0;

  precursor_tolerance_merge #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .mass_to_charge_i(mass_to_charge_i),
    .retention_time_i(retention_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .query_number_o  (query_number_o),
    .merged_mass_o   (merged_mass_o),
    .matched_o       (matched_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [VAL_W-1:0] distance(input logic [VAL_W-1:0] a, b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // scoreboard: apply one accepted item, predict the result of a query
  task automatic predict_merge(input item_t it);
    merge_t         res;
    logic [VAL_W:0] total;
    case (it.req)
      REQ_CLEAR: begin
        lib_count = 0;
        query_seq = '0;
      end
      REQ_LOAD: begin
        if (lib_count < DEPTH) begin
          lib_mass[lib_count] = it.mz;
          lib_time[lib_count] = it.rt;
          lib_count++;
        end
      end
      REQ_QUERY: begin
        if (query_seq != QNUM_MAX) query_seq++;
        res.qnum   = query_seq;
        res.merged = it.mz;
        res.hit    = 1'b0;
        // first entry inside both windows wins
        for (int i = 0; i < lib_count; i++) begin
          if (!res.hit && distance(it.mz, lib_mass[i]) <= win_mz &&
              distance(it.rt, lib_time[i]) <= win_rt) begin
            total      = {1'b0, it.mz} + {1'b0, lib_mass[i]};
            res.merged = total[VAL_W:1];
            res.hit    = 1'b1;
          end
        end
        merge_queue.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic apply_window(input item_t it);
    if (it.index == CFG_IDX_MZ_TOL) win_mz = it.data;
    else if (it.index == CFG_IDX_TIME_TOL) win_rt = it.data;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    item_t head;
    logic  in_hold;
    logic  cfg_hold;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      settle_count = 0;
    end else begin
      in_hold  = in_valid_i;
      cfg_hold = cfg_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_merge(item_queue.pop_front());
        in_hold = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_window(item_queue.pop_front());
        cfg_hold = 1'b0;
      end
      // count quiet cycles so writes land only on an idle block
      if (merge_queue.size() == 0 && !in_hold && !cfg_hold) settle_count++;
      else settle_count = 0;
      if (!in_hold && !cfg_hold && item_queue.size() != 0) begin
        head     = item_queue[0];
        calm_now = head.calm;
        if (head.calm || $urandom_range(0, 99) >= IDLE_PCT) begin
          if (head.is_cfg) begin
            if (settle_count >= SETTLE_CYCLES) begin
              cfg_hold = 1'b1;
              cfg_index_i <= head.index;
              cfg_data_i  <= head.data;
            end
          end else begin
            in_hold = 1'b1;
            req_type_i       <= head.req;
            mass_to_charge_i <= head.mz;
            retention_time_i <= head.rt;
          end
        end
      end
      in_valid_i  <= in_hold;
      cfg_valid_i <= cfg_hold;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    merge_t exp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (merge_queue.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual qnum %0d mass %h hit %b",
                   $time, query_number_o, merged_mass_o, matched_o);
          mismatch_count++;
        end else begin
          exp = merge_queue.pop_front();
          if (query_number_o !== exp.qnum) begin
            $display("%0t: query_number expected %0d actual %0d",
                     $time, exp.qnum, query_number_o);
            mismatch_count++;
          end
          if (merged_mass_o !== exp.merged) begin
            $display("%0t: merged_mass expected %h actual %h",
                     $time, exp.merged, merged_mass_o);
            mismatch_count++;
          end
          if (matched_o !== exp.hit) begin
            $display("%0t: matched expected %b actual %b", $time, exp.hit, matched_o);
            mismatch_count++;
          end
        end
      end
      out_ready_i <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // stimulus helpers
  task automatic push_item(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] mz, rt);
    item_t it;
    it.is_cfg = 1'b0;
    it.calm   = gen_calm;
    it.index  = '0;
    it.data   = '0;
    it.req    = req;
    it.mz     = mz;
    it.rt     = rt;
    item_queue.push_back(it);
    if (req != REQ_UNUSED) stim_total++;
    if (req == REQ_CLEAR) staged_count = 0;
    if (req == REQ_LOAD && staged_count < DEPTH) begin
      staged_mass[staged_count] = mz;
      staged_time[staged_count] = rt;
      staged_count++;
    end
  endtask

  task automatic push_window(input logic [CFG_INDEX_W-1:0] index,
                             input logic [VAL_W-1:0] data);
    item_t it;
    it.is_cfg = 1'b1;
    it.calm   = gen_calm;
    it.index  = index;
    it.data   = data;
    it.req    = REQ_UNUSED;
    it.mz     = '0;
    it.rt     = '0;
    item_queue.push_back(it);
    if (index == CFG_IDX_MZ_TOL) gen_mz_tol = data;
    else if (index == CFG_IDX_TIME_TOL) gen_rt_tol = data;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      3: return ~$urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_tol(input logic [VAL_W-1:0] dflt);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return dflt;
      3: return $urandom_range(0, 1 << 20);
      4: return $urandom_range(0, 1 << 28);
      default: return $urandom();
    endcase
  endfunction

  // value near a stored one, often right at the window edge
  function automatic logic [VAL_W-1:0] nudge(input logic [VAL_W-1:0] base, tol);
    logic [VAL_W-1:0] delta;
    case ($urandom_range(0, 5))
      0: delta = '0;
      1: delta = tol;
      2: delta = tol + 1;
      3: delta = $urandom_range(0, tol);
      4: delta = tol + $urandom_range(2, 300);
      default: delta = $urandom();
    endcase
    return $urandom_range(0, 1) ? base + delta : base - delta;
  endfunction

  // one random phase: maybe new windows, maybe a clear, loads, then queries mixed with loads and unused codes
  task automatic stage_session();
    int loads;
    int queries;
    int pick;
    int j;
    if ($urandom_range(0, 2) == 0) begin
      push_window(CFG_IDX_MZ_TOL, pick_tol(MZ_TOL_RESET));
      if ($urandom_range(0, 3) != 0) push_window(CFG_IDX_TIME_TOL, pick_tol(TIME_TOL_RESET));
      if ($urandom_range(0, 4) == 0) push_window(CFG_INDEX_W'($urandom_range(2, 255)),
                                                 $urandom());
    end
    if ($urandom_range(0, 3) != 0) push_item(REQ_CLEAR, $urandom(), $urandom());
    loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 20);
    queries = $urandom_range(4, 20);
    for (int n = 0; n < loads; n++) push_item(REQ_LOAD, pick_value(), pick_value());
    for (int n = 0; n < queries; n++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        push_item(REQ_UNUSED, $urandom(), $urandom());
      end else if (pick == 1) begin
        push_item(REQ_LOAD, pick_value(), pick_value());
      end else if (pick < 7 && staged_count != 0) begin
        j = $urandom_range(0, staged_count - 1);
        push_item(REQ_QUERY, nudge(staged_mass[j], gen_mz_tol),
                  nudge(staged_time[j], gen_rt_tol));
      end else begin
        push_item(REQ_QUERY, pick_value(), pick_value());
      end
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    int base;
    int j;

    // default windows: empty table, extremes, window edges
    push_item(REQ_QUERY, 32'd123, 32'd456);
    push_item(REQ_LOAD, 32'h0000_0000, 32'h0000_0000);
    push_item(REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(REQ_LOAD, 32'd1000, 32'd1310720);
    push_item(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
    push_item(REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(REQ_QUERY, 32'd655, 32'd655360);
    push_item(REQ_QUERY, 32'd656, 32'd0);
    push_item(REQ_QUERY, 32'd1655, 32'd655360);
    push_item(REQ_UNUSED, $urandom(), $urandom());
    push_item(REQ_CLEAR, $urandom(), $urandom());
    push_item(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);

    // widest windows, plus a write to an unused index
    push_window(CFG_IDX_MZ_TOL, '1);
    push_window(CFG_IDX_TIME_TOL, '1);
    push_window(8'hFF, $urandom());
    push_item(REQ_LOAD, 32'hFFFF_FFFF, 32'h0000_0000);
    push_item(REQ_LOAD, 32'd5, 32'd5);
    push_item(REQ_QUERY, 32'h0000_0000, 32'hFFFF_FFFF);
    push_item(REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // zero windows: exact matches only
    push_window(CFG_IDX_MZ_TOL, '0);
    push_window(CFG_IDX_TIME_TOL, '0);
    push_item(REQ_QUERY, 32'd5, 32'd5);
    push_item(REQ_QUERY, 32'd5, 32'd6);
    push_item(REQ_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);

    // random phases
    while (stim_total < 480) stage_session();

    // long stretch with no idling on either side
    gen_calm = 1'b1;
    push_item(REQ_CLEAR, $urandom(), $urandom());
    for (int n = 0; n < 4; n++) push_item(REQ_LOAD, pick_value(), pick_value());
    for (int n = 0; n < 60; n++) begin
      if (n % 2 == 0) begin
        j = $urandom_range(0, staged_count - 1);
        push_item(REQ_QUERY, nudge(staged_mass[j], gen_mz_tol),
                  nudge(staged_time[j], gen_rt_tol));
      end else begin
        push_item(REQ_QUERY, pick_value(), pick_value());
      end
    end
    gen_calm = 1'b0;

    base = stim_total;
    while (stim_total < base + 250) stage_session();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_queue.size() != 0 || merge_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && merge_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #48000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
